[design/wvhp_pkg.sv]
// shared types, constants and codes for the wave header chunk parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package wvhp_pkg;

  // widths of the fields and registers
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 32;
  localparam int RATE_W      = 16;
  localparam int CHAN_W      = 2;
  localparam int BITS_W      = 5;
  localparam int RELOAD_W    = 8;
  localparam int SPEED_W     = 3;
  localparam int CLOCK_W     = 27;
  localparam int CFG_INDEX_W = 1;
  localparam int OUT_DATA_W  = 64;

  // shared divider: dividend as wide as the clock word, divisor as wide as the sample rate
  localparam int DIVIDEND_W = CLOCK_W;
  localparam int DIVISOR_W  = RATE_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
  localparam int DIVISOR_EXT_W = DIVISOR_W - SPEED_W - 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK = 1'b1;

  localparam logic [SPEED_W-1:0] SPEED_RESET = '0;
  localparam logic [CLOCK_W-1:0] CLOCK_RESET = 27'd16000000;

  // chunk identifiers, little-endian four-character codes
  localparam logic [WORD_W-1:0] ID_WAVE = 32'h4556_4157;
  localparam logic [WORD_W-1:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [WORD_W-1:0] ID_DATA = 32'h6174_6164;
  localparam logic [WORD_W-1:0] ID_LIST = 32'h5453_494C;
  localparam logic [WORD_W-1:0] ID_FACT = 32'h7463_6166;

  // fmt chunk limits and field offsets
  localparam logic [WORD_W-1:0] FMT_LEN_MIN = 32'd16;
  localparam logic [WORD_W-1:0] FMT_LEN_MAX = 32'd100;
  localparam logic [WORD_W-1:0] POS_FORMAT  = 32'd0;
  localparam logic [WORD_W-1:0] POS_CHAN    = 32'd2;
  localparam logic [WORD_W-1:0] POS_RATE_LO = 32'd4;
  localparam logic [WORD_W-1:0] POS_RATE_HI = 32'd5;
  localparam logic [WORD_W-1:0] POS_BITS    = 32'd14;

  // header layout
  localparam logic [WORD_W-1:0] POS_HDR_ID   = 32'd8;
  localparam logic [WORD_W-1:0] POS_HDR_LAST = 32'd11;
  localparam logic [WORD_W-1:0] POS_CHDR_LEN = 32'd4;
  localparam logic [WORD_W-1:0] POS_CHDR_END = 32'd7;

  localparam logic [BYTE_W-1:0] FORMAT_PCM = 8'd1;
  localparam logic [BYTE_W-1:0] CHAN_MONO  = 8'd1;
  localparam logic [BYTE_W-1:0] CHAN_STEREO = 8'd2;
  localparam logic [BYTE_W-1:0] BITS_8     = 8'd8;
  localparam logic [BYTE_W-1:0] BITS_16    = 8'd16;
  localparam logic [SPEED_W:0]  SPEED_BASE = 4'd8;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_CHDR,
    PH_FMT,
    PH_SKIP,
    PH_DIV_CLK,
    PH_DIV_RATE
  } phase_t;

  // which field a byte is captured into
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_HDR,
    SEL_CHDR,
    SEL_FMT
  } sel_t;

  typedef struct packed {
    logic clear;
    sel_t sel;
    logic pos_inc;
    logic pos_clear;
    logic enter_chdr;
    logic fmt_enter;
    logic div_start_clk;
    logic div_start_rate;
    logic fmt_done;
    logic emit_ok;
    logic emit_bad;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pos_is_hdr_last;
    logic pos_is_chdr_end;
    logic pos_end;
    logic id_wave;
    logic id_fmt;
    logic id_data;
    logic id_skip;
    logic len_fmt_ok;
    logic len_zero;
    logic fmt_ok;
    logic div_done;
  } dp_status_t;

  typedef struct packed {
    logic                status;
    logic [WORD_W-1:0]   data_length;
    logic [RATE_W-1:0]   sample_rate;
    logic [CHAN_W-1:0]   channel_count;
    logic [BITS_W-1:0]   sample_bits;
    logic                format_seen;
    logic [RELOAD_W-1:0] timer_reload;
  } res_t;

endpackage

[design/wvhp_div.sv]
// restoring divider, one quotient bit per cycle
// depends on wvhp_pkg
`timescale 1ns / 1ps

module wvhp_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [wvhp_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [wvhp_pkg::DIVISOR_W-1:0]  divisor,
  output logic                            done,
  output logic [wvhp_pkg::DIVIDEND_W-1:0] quotient
);
  import wvhp_pkg::*;

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // one trial subtraction per cycle
  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= DIV_CNT_W'(DIVIDEND_W - 1);
    end else if (busy) begin
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient = quo;

endmodule

[design/wvhp_ctrl.sv]
// parse controller: phase state machine issuing datapath commands
// depends on wvhp_pkg
`timescale 1ns / 1ps

module wvhp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic                 s_tuser,
  input  logic                 s_tlast,
  input  logic                 room,
  input  wvhp_pkg::dp_status_t st,
  output wvhp_pkg::ctrl_cmd_t  cmd
);
  import wvhp_pkg::*;

  phase_t state;
  phase_t state_next;
  phase_t eff_phase;
  logic   take;
  logic   emitted;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    cmd.sel    = SEL_NONE;
    state_next = state;
    emitted    = 1'b0;
    s_tready   = room && (state != PH_DIV_CLK) && (state != PH_DIV_RATE);
    take       = s_tvalid && s_tready;
    eff_phase  = s_tuser ? PH_HEADER : state;

    if (take) begin
      cmd.clear = s_tuser;
      case (eff_phase)
        PH_HEADER: begin
          cmd.sel     = SEL_HDR;
          cmd.pos_inc = 1'b1;
          if (st.pos_is_hdr_last) begin
            if (!st.id_wave) begin
              cmd.emit_bad = 1'b1;
            end else begin
              cmd.enter_chdr = 1'b1;
              state_next     = PH_CHDR;
            end
          end else begin
            state_next = PH_HEADER;
          end
        end
        PH_CHDR: begin
          cmd.sel     = SEL_CHDR;
          cmd.pos_inc = 1'b1;
          if (st.pos_is_chdr_end) begin
            cmd.pos_clear = 1'b1;
            if (st.id_fmt) begin
              if (!st.len_fmt_ok) begin
                cmd.emit_bad = 1'b1;
              end else begin
                cmd.fmt_enter = 1'b1;
                state_next    = PH_FMT;
              end
            end else if (st.id_data) begin
              cmd.emit_ok = 1'b1;
            end else if (st.id_skip) begin
              if (st.len_zero) begin
                cmd.enter_chdr = 1'b1;
              end else begin
                state_next = PH_SKIP;
              end
            end else begin
              cmd.emit_bad = 1'b1;
            end
          end
        end
        PH_FMT: begin
          cmd.sel     = SEL_FMT;
          cmd.pos_inc = 1'b1;
          if (st.pos_end) begin
            if (!st.fmt_ok) begin
              cmd.emit_bad = 1'b1;
            end else if (!s_tlast) begin
              cmd.div_start_clk = 1'b1;
              state_next        = PH_DIV_CLK;
            end
          end
        end
        PH_SKIP: begin
          cmd.pos_inc = 1'b1;
          if (st.pos_end) begin
            cmd.enter_chdr = 1'b1;
            state_next     = PH_CHDR;
          end
        end
        default: begin
        end
      endcase

      emitted = cmd.emit_ok || cmd.emit_bad;
      // end of stream in the middle of a parse
      if (eff_phase != PH_IDLE && !emitted && s_tlast) begin
        cmd.emit_bad = 1'b1;
        emitted      = 1'b1;
      end
      if (emitted) begin
        state_next = PH_IDLE;
      end
    end else begin
      case (state)
        PH_DIV_CLK: begin
          if (st.div_done) begin
            cmd.div_start_rate = 1'b1;
            state_next         = PH_DIV_RATE;
          end
        end
        PH_DIV_RATE: begin
          if (st.div_done) begin
            cmd.fmt_done   = 1'b1;
            cmd.enter_chdr = 1'b1;
            state_next     = PH_CHDR;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[design/wvhp_dp.sv]
// parse datapath: position counter, identifier and length words, fmt fields,
// configuration registers and the reload divider; depends on wvhp_pkg, wvhp_div
`timescale 1ns / 1ps

module wvhp_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [wvhp_pkg::BYTE_W-1:0]       data_byte,
  input  logic                              cfg_valid,
  input  logic [wvhp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wvhp_pkg::CLOCK_W-1:0]      cfg_data,
  input  wvhp_pkg::ctrl_cmd_t               cmd,
  output wvhp_pkg::dp_status_t              st,
  output logic                              res_push,
  output wvhp_pkg::res_t                    res
);
  import wvhp_pkg::*;

  logic [SPEED_W-1:0]    speed_setting;
  logic [CLOCK_W-1:0]    clock_hz;

  logic [WORD_W-1:0]     byte_position;
  logic [WORD_W-1:0]     chunk_ident;
  logic [WORD_W-1:0]     chunk_length;
  logic                  format_pcm;
  logic                  chan_ok;
  logic [CHAN_W-1:0]     channels_held;
  logic                  bits_ok;
  logic [BITS_W-1:0]     bits_held;
  logic [RATE_W-1:0]     rate_held;
  logic [RELOAD_W-1:0]   reload_held;
  logic                  format_valid;

  logic [WORD_W-1:0]     pos_eff;
  logic [WORD_W-1:0]     ident_eff;
  logic [WORD_W-1:0]     length_eff;
  logic [WORD_W-1:0]     ident_next;
  logic [WORD_W-1:0]     length_next;
  logic [WORD_W-1:0]     pos_plus;
  logic [WORD_W-1:0]     lane_word;

  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIVIDEND_W-1:0] div_quotient;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_setting <= SPEED_RESET;
      clock_hz      <= CLOCK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SPEED: speed_setting <= cfg_data[SPEED_W-1:0];
        CFG_CLOCK: clock_hz      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // a new file starts from cleared words
  assign pos_eff    = cmd.clear ? '0 : byte_position;
  assign ident_eff  = cmd.clear ? '0 : chunk_ident;
  assign length_eff = cmd.clear ? '0 : chunk_length;
  assign pos_plus   = pos_eff + 1'b1;
  assign lane_word  = {{(WORD_W-BYTE_W){1'b0}}, data_byte} << {pos_eff[1:0], 3'b000};

  // byte capture into the identifier and length words
  always_comb begin
    ident_next  = ident_eff;
    length_next = length_eff;
    case (cmd.sel)
      SEL_HDR: begin
        if (pos_eff >= POS_HDR_ID) begin
          ident_next = ident_eff | lane_word;
        end
      end
      SEL_CHDR: begin
        if (pos_eff < POS_CHDR_LEN) begin
          ident_next = ident_eff | lane_word;
        end else begin
          length_next = length_eff | lane_word;
        end
      end
      default: begin
      end
    endcase
  end

  // status towards the controller
  always_comb begin
    st.pos_is_hdr_last = pos_eff == POS_HDR_LAST;
    st.pos_is_chdr_end = pos_eff == POS_CHDR_END;
    st.pos_end         = pos_plus == length_eff;
    st.id_wave         = ident_next == ID_WAVE;
    st.id_fmt          = ident_next == ID_FMT;
    st.id_data         = ident_next == ID_DATA;
    st.id_skip         = (ident_next == ID_LIST) || (ident_next == ID_FACT);
    st.len_fmt_ok      = (length_next >= FMT_LEN_MIN) && (length_next <= FMT_LEN_MAX);
    st.len_zero        = length_next == '0;
    st.fmt_ok          = format_pcm && chan_ok && bits_ok && (rate_held != '0);
    st.div_done        = div_done;
  end

  // parse words
  always_ff @(posedge clk) begin
    if (cmd.enter_chdr || cmd.pos_clear) begin
      byte_position <= '0;
    end else if (cmd.pos_inc) begin
      byte_position <= pos_plus;
    end
    if (cmd.enter_chdr) begin
      chunk_ident  <= '0;
      chunk_length <= '0;
    end else if (cmd.clear || cmd.sel != SEL_NONE) begin
      chunk_ident  <= ident_next;
      chunk_length <= length_next;
    end
  end

  // fmt fields
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      format_pcm    <= 1'b0;
      chan_ok       <= 1'b0;
      channels_held <= '0;
      bits_ok       <= 1'b0;
      bits_held     <= '0;
      rate_held     <= '0;
      reload_held   <= '0;
    end else if (cmd.fmt_enter) begin
      rate_held <= '0;
    end else if (cmd.sel == SEL_FMT) begin
      if (pos_eff == POS_FORMAT) begin
        format_pcm <= data_byte == FORMAT_PCM;
      end
      if (pos_eff == POS_CHAN) begin
        chan_ok       <= (data_byte == CHAN_MONO) || (data_byte == CHAN_STEREO);
        channels_held <= data_byte[CHAN_W-1:0];
      end
      if (pos_eff == POS_RATE_LO) begin
        rate_held[BYTE_W-1:0] <= data_byte;
      end
      if (pos_eff == POS_RATE_HI) begin
        rate_held[RATE_W-1:BYTE_W] <= data_byte;
      end
      if (pos_eff == POS_BITS) begin
        bits_ok   <= (data_byte == BITS_8) || (data_byte == BITS_16);
        bits_held <= data_byte[BITS_W-1:0];
      end
    end else if (cmd.fmt_done) begin
      reload_held <= div_quotient[RELOAD_W-1:0] - 1'b1;
    end
  end

  // format flag
  always_ff @(posedge clk) begin
    if (rst) begin
      format_valid <= 1'b0;
    end else if (cmd.clear || cmd.fmt_enter) begin
      format_valid <= 1'b0;
    end else if (cmd.fmt_done) begin
      format_valid <= 1'b1;
    end
  end

  // reload divider: clock over (8 + speed), then over the sample rate
  assign div_start    = cmd.div_start_clk || cmd.div_start_rate;
  assign div_dividend = cmd.div_start_rate ? div_quotient : clock_hz;
  assign div_divisor  = cmd.div_start_rate ? rate_held
                                           : {{DIVISOR_EXT_W{1'b0}},
                                              SPEED_BASE + {1'b0, speed_setting}};

  wvhp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // result word
  always_comb begin
    res          = '0;
    res.status   = cmd.emit_bad;
    if (cmd.emit_ok) begin
      res.data_length = length_next;
      if (format_valid) begin
        res.sample_rate   = rate_held;
        res.channel_count = channels_held;
        res.sample_bits   = bits_held;
        res.format_seen   = 1'b1;
        res.timer_reload  = reload_held;
      end
    end
  end

  assign res_push = cmd.emit_ok || cmd.emit_bad;

endmodule

[design/wvhp_out_buf.sv]
// two-word result queue between the parser and the output stream
// depends on wvhp_pkg
`timescale 1ns / 1ps

module wvhp_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wvhp_pkg::res_t push_res,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output wvhp_pkg::res_t out_res
);
  import wvhp_pkg::*;

  logic v0;
  logic v1;
  res_t d0;
  res_t d1;
  logic pop;

  assign pop = v0 && out_ready;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (pop) begin
      if (v1) begin
        v1 <= push;
      end else begin
        v0 <= push;
      end
    end else if (push) begin
      if (!v0) begin
        v0 <= 1'b1;
      end else begin
        v1 <= 1'b1;
      end
    end
  end

  // stored words
  always_ff @(posedge clk) begin
    if (pop) begin
      if (v1) begin
        d0 <= d1;
        if (push) begin
          d1 <= push_res;
        end
      end else if (push) begin
        d0 <= push_res;
      end
    end else if (push) begin
      if (!v0) begin
        d0 <= push_res;
      end else begin
        d1 <= push_res;
      end
    end
  end

  assign room      = !v1;
  assign out_valid = v0;
  assign out_res   = d0;

endmodule

[design/wave_header_chunk_parser.sv]
// top level of the wave header chunk parser
// depends on wvhp_pkg, wvhp_ctrl, wvhp_dp, wvhp_div, wvhp_out_buf
`timescale 1ns / 1ps

// Takes a WAVE file one byte per word on the slave stream (tuser marks the
// first byte and restarts the parse, tlast the final byte) and returns one
// result word when the data chunk header is reached, or when the stream is
// malformed or ends early. At the end of a valid fmt chunk the input stalls
// while a one-bit-per-cycle divider works out the timer reload in two
// 27-step passes (clock over 8 + speed, then over the sample rate). Up to two
// result words are held, so a new byte is taken while a result still waits;
// apart from the divider passes, the input only waits when both are held.
// Configuration is written on the cfg port (index 0 speed, index 1 clock in
// hertz); the user must write it only while idle, the block does not enforce it.

module wave_header_chunk_parser (
  input  logic                              clk,
  input  logic                              rst,
  // tdata: data_byte [7:0]
  input  logic [7:0]                        s_tdata,
  // tuser: first
  input  logic                              s_tuser,
  input  logic                              s_tlast,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tdata: data_length [31:0], sample_rate [47:32], channel_count [49:48],
  //        sample_bits [54:50], format_seen [55], timer_reload [63:56]
  output logic [wvhp_pkg::OUT_DATA_W-1:0]   m_tdata,
  // tuser: status
  output logic                              m_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wvhp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wvhp_pkg::CLOCK_W-1:0]      cfg_data
);
  import wvhp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic       room;
  logic       res_push;
  res_t       res;
  res_t       out_res;

  assign cfg_ready = 1'b1;

  wvhp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .room     (room),
    .st       (st),
    .cmd      (cmd)
  );

  wvhp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .res_push  (res_push),
    .res       (res)
  );

  wvhp_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_res  (res),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // pack the result word
  assign m_tuser = out_res.status;
  assign m_tdata = {out_res.timer_reload, out_res.format_seen, out_res.sample_bits,
                    out_res.channel_count, out_res.sample_rate, out_res.data_length};

endmodule

[tb/sv/wave_header_chunk_parser_test.sv]
// testbench for wave_header_chunk_parser: directed and random wave files sent byte by byte
// results checked field by field against an in-bench parse of the same bytes
// depends on wvhp_pkg and the design sources
`timescale 1ns / 1ps

module wave_header_chunk_parser_test;
  import wvhp_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 2000;
  localparam int IDLE_PCT      = 30;
  localparam int PRINT_CAP     = 40;
  localparam logic [WORD_W-1:0] ID_RIFF = 32'h4646_4952;

  logic                  clk;
  logic                  rst;
  logic [7:0]            s_tdata;
  logic                  s_tuser;
  logic                  s_tlast;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CLOCK_W-1:0]    cfg_data;

  wave_header_chunk_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock, 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // bench state
  res_t       pending_results[$];
  logic [7:0] file_bytes[$];
  int         parsed_bytes;
  int         results_seen;
  int         errors;
  int         stall_cycles;
  bit         src_calm;
  bit         sink_calm;
  bit         valid_up;

  // parser copy: registers and parse state
  logic [SPEED_W-1:0] speed_q;
  logic [CLOCK_W-1:0] clock_q;
  phase_t             parse_ph;
  logic [31:0]        sec_pos;
  logic [31:0]        cur_id;
  logic [31:0]        cur_len;
  logic [7:0]         fmt_code;
  logic [7:0]         chan_cnt;
  logic [15:0]        rate_val;
  logic [7:0]         bits_val;
  logic [7:0]         reload_val;
  logic               fmt_valid;

  function automatic void clear_parse_state();
    parse_ph   = PH_IDLE;
    sec_pos    = '0;
    cur_id     = '0;
    cur_len    = '0;
    fmt_code   = '0;
    chan_cnt   = '0;
    rate_val   = '0;
    bits_val   = '0;
    reload_val = '0;
    fmt_valid  = 1'b0;
  endfunction

  function automatic void open_chunk();
    parse_ph = PH_CHDR;
    sec_pos  = '0;
    cur_id   = '0;
    cur_len  = '0;
  endfunction

  // walk one accepted byte and queue the result word it causes, if any
  function automatic void parse_byte(input logic [7:0] b, input logic f, input logic l);
    res_t        r;
    logic [31:0] p;
    logic [31:0] q;
    bit          done;
    r = '0;
    done = 1'b0;
    if (f) begin
      clear_parse_state();
      parse_ph = PH_HEADER;
    end
    if (parse_ph == PH_IDLE) return;
    parsed_bytes++;
    p = sec_pos;
    sec_pos = p + 1;
    case (parse_ph)
      PH_HEADER: begin
        if (p >= POS_HDR_ID) cur_id |= 32'(b) << (8 * (p - POS_HDR_ID));
        if (p == POS_HDR_LAST) begin
          if (cur_id != ID_WAVE) begin
            r.status = 1'b1;
            done = 1'b1;
          end else begin
            open_chunk();
          end
        end
      end
      PH_CHDR: begin
        if (p < POS_CHDR_LEN) cur_id |= 32'(b) << (8 * p);
        else cur_len |= 32'(b) << (8 * (p - POS_CHDR_LEN));
        if (p == POS_CHDR_END) begin
          sec_pos = '0;
          if (cur_id == ID_FMT) begin
            if (cur_len > FMT_LEN_MAX || cur_len < FMT_LEN_MIN) begin
              r.status = 1'b1;
              done = 1'b1;
            end else begin
              fmt_valid = 1'b0;
              rate_val = '0;
              parse_ph = PH_FMT;
            end
          end else if (cur_id == ID_DATA) begin
            done = 1'b1;
            r.data_length = cur_len;
            if (fmt_valid) begin
              r.sample_rate   = rate_val;
              r.channel_count = chan_cnt[CHAN_W-1:0];
              r.sample_bits   = bits_val[BITS_W-1:0];
              r.format_seen   = 1'b1;
              r.timer_reload  = reload_val;
            end
          end else if (cur_id == ID_LIST || cur_id == ID_FACT) begin
            if (cur_len == 0) open_chunk();
            else parse_ph = PH_SKIP;
          end else begin
            r.status = 1'b1;
            done = 1'b1;
          end
        end
      end
      PH_FMT: begin
        if (p == POS_FORMAT) fmt_code = b;
        else if (p == POS_CHAN) chan_cnt = b;
        else if (p == POS_RATE_LO) rate_val[7:0] = b;
        else if (p == POS_RATE_HI) rate_val[15:8] = b;
        else if (p == POS_BITS) bits_val = b;
        if (sec_pos == cur_len) begin
          if (fmt_code != FORMAT_PCM || !(chan_cnt == CHAN_MONO || chan_cnt == CHAN_STEREO)
              || !(bits_val == BITS_8 || bits_val == BITS_16) || rate_val == 0) begin
            r.status = 1'b1;
            done = 1'b1;
          end else begin
            // two truncating divisions, kept modulo 256
            q = 32'(clock_q) / (32'(SPEED_BASE) + 32'(speed_q));
            q = q / 32'(rate_val);
            reload_val = 8'(q - 1);
            fmt_valid = 1'b1;
            open_chunk();
          end
        end
      end
      PH_SKIP: begin
        if (sec_pos == cur_len) open_chunk();
      end
      default: ;
    endcase
    // end of stream while a parse is still open
    if (!done && l && parse_ph != PH_IDLE) begin
      r = '0;
      r.status = 1'b1;
      done = 1'b1;
    end
    if (done) begin
      parse_ph = PH_IDLE;
      pending_results.push_back(r);
    end
  endfunction

  task automatic report_error(input string msg);
    if (errors < PRINT_CAP) $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got 0x%0h expected 0x%0h",
                             results_seen, name, got, want));
  endtask

  task automatic check_result();
    res_t want;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result word with none expected: tdata 0x%h status %b",
                             m_tdata, m_tuser));
      return;
    end
    want = pending_results.pop_front();
    results_seen++;
    compare_field("status", 32'(m_tuser), 32'(want.status));
    compare_field("data_length", m_tdata[31:0], want.data_length);
    compare_field("sample_rate", 32'(m_tdata[47:32]), 32'(want.sample_rate));
    compare_field("channel_count", 32'(m_tdata[49:48]), 32'(want.channel_count));
    compare_field("sample_bits", 32'(m_tdata[54:50]), 32'(want.sample_bits));
    compare_field("format_seen", 32'(m_tdata[55]), 32'(want.format_seen));
    compare_field("timer_reload", 32'(m_tdata[63:56]), 32'(want.timer_reload));
  endtask

  // result side: random back-pressure and checking of every taken word
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      m_tready <= sink_calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles with no word moving on any port
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("wave_header_chunk_parser test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // file builders, little-endian
  function automatic void put_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) file_bytes.push_back(w[8*k +: 8]);
  endfunction

  function automatic void put_random(input int n);
    for (int k = 0; k < n; k++) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_chunk_hdr(input logic [31:0] id, input logic [31:0] len);
    put_word(id);
    put_word(len);
  endfunction

  function automatic void make_file(input logic [31:0] wave_id);
    file_bytes.delete();
    put_word(ID_RIFF);
    put_word($urandom);
    put_word(wave_id);
  endfunction

  function automatic void put_fmt(input int len, input logic [7:0] code, input logic [7:0] chan,
                                  input logic [15:0] rate, input logic [7:0] bits);
    put_chunk_hdr(ID_FMT, len);
    for (int i = 0; i < len; i++) begin
      if (i == POS_FORMAT) file_bytes.push_back(code);
      else if (i == POS_CHAN) file_bytes.push_back(chan);
      else if (i == POS_RATE_LO) file_bytes.push_back(rate[7:0]);
      else if (i == POS_RATE_HI) file_bytes.push_back(rate[15:8]);
      else if (i == POS_BITS) file_bytes.push_back(bits);
      else file_bytes.push_back(8'($urandom));
    end
  endfunction

  function automatic void put_data(input logic [31:0] len, input int body);
    put_chunk_hdr(ID_DATA, len);
    put_random(body);
  endfunction

  function automatic void put_skip_random();
    int len;
    len = ($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(40, 7);
    put_chunk_hdr($urandom_range(1) ? ID_LIST : ID_FACT, len);
    put_random(len);
  endfunction

  function automatic void cut_file(input int keep);
    file_bytes = file_bytes[0:keep-1];
  endfunction

  // send one byte word, with an occasional gap before it
  task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
    if (!src_calm && $urandom_range(99) < IDLE_PCT) begin
      if (valid_up) s_tvalid <= 1'b0;
      valid_up = 1'b0;
      s_tdata <= 8'($urandom);
      s_tuser <= 1'($urandom);
      s_tlast <= 1'($urandom);
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    s_tdata  <= b;
    s_tuser  <= f;
    s_tlast  <= l;
    s_tvalid <= 1'b1;
    valid_up = 1'b1;
    do @(posedge clk); while (!s_tready);
    parse_byte(b, f, l);
  endtask

  task automatic send_file(input bit mark_last);
    int n;
    n = file_bytes.size();
    for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == 0, mark_last && i == n - 1);
  endtask

  task automatic drain_expected();
    if (valid_up) s_tvalid <= 1'b0;
    valid_up = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // quiet time before a register write, covers a divider still running
  task automatic settle_idle();
    drain_expected();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [SPEED_W-1:0] speed, input logic [CLOCK_W-1:0] hz);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SPEED;
    cfg_data  <= CLOCK_W'(speed);
    do @(posedge clk); while (!cfg_ready);
    speed_q = speed;
    cfg_index <= CFG_CLOCK;
    cfg_data  <= hz;
    do @(posedge clk); while (!cfg_ready);
    clock_q = hz;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_fmt_file(input logic [7:0] code, input logic [7:0] chan,
                               input logic [15:0] rate, input logic [7:0] bits);
    make_file(ID_WAVE);
    put_fmt(FMT_LEN_MIN, code, chan, rate, bits);
    put_data($urandom, 1);
    send_file(1'b1);
  endtask

  // reload from the register values left by reset
  task automatic test_reset_defaults();
    send_fmt_file(FORMAT_PCM, CHAN_MONO, 16'd8000, BITS_8);
    send_fmt_file(FORMAT_PCM, CHAN_STEREO, 16'd44100, BITS_16);
  endtask

  task automatic test_header_cases();
    // data chunk with no fmt before it, with and without tlast on its final header byte
    make_file(ID_WAVE);
    put_data(32'd0, 0);
    send_file(1'b1);
    make_file(ID_WAVE);
    put_data(32'hFFFF_FFFF, 0);
    send_file(1'b0);
    // wrong form type in the header
    make_file(~ID_WAVE);
    put_data(32'd5, 0);
    send_file(1'b1);
    // single-byte file
    send_byte(8'hFF, 1'b1, 1'b1);
    // bytes with no start marker are dropped while idle
    repeat (3) send_byte(8'($urandom), 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    // stream ends inside the header
    make_file(ID_WAVE);
    cut_file(11);
    send_file(1'b1);
    // a new file starts before the old one ends
    make_file(ID_WAVE);
    put_chunk_hdr(ID_LIST, 32'd20);
    put_random(5);
    send_file(1'b0);
    // skip chunks of zero and non-zero length ahead of fmt
    make_file(ID_WAVE);
    put_chunk_hdr(ID_LIST, 32'd0);
    put_chunk_hdr(ID_FACT, 32'd4);
    put_random(4);
    put_fmt(FMT_LEN_MIN, FORMAT_PCM, CHAN_MONO, 16'd11025, BITS_16);
    put_data(32'h8000_0001, 1);
    send_file(1'b1);
    // unknown chunk id
    make_file(ID_WAVE);
    put_chunk_hdr(32'h6B6E_756A, 32'd4);
    put_random(4);
    send_file(1'b1);
    // stream ends inside a skipped body, inside fmt, and on the last fmt byte
    make_file(ID_WAVE);
    put_chunk_hdr(ID_FACT, 32'd10);
    put_random(3);
    send_file(1'b1);
    make_file(ID_WAVE);
    put_fmt(FMT_LEN_MIN, FORMAT_PCM, CHAN_STEREO, 16'd22050, BITS_8);
    cut_file(file_bytes.size() - 3);
    send_file(1'b1);
    make_file(ID_WAVE);
    put_fmt(FMT_LEN_MIN, FORMAT_PCM, CHAN_STEREO, 16'd22050, BITS_8);
    send_file(1'b1);
  endtask

  task automatic test_fmt_cases();
    int sizes[4];
    sizes = '{15, 16, 100, 101};
    // fmt length limits
    foreach (sizes[k]) begin
      make_file(ID_WAVE);
      put_fmt(sizes[k], FORMAT_PCM, CHAN_MONO, 16'd32000, BITS_16);
      put_data(sizes[k], 0);
      send_file(1'b1);
    end
    // format code, channel, sample size and rate checks
    send_fmt_file(8'd0, CHAN_MONO, 16'd1000, BITS_8);
    send_fmt_file(8'hFF, CHAN_MONO, 16'd1000, BITS_8);
    send_fmt_file(FORMAT_PCM, 8'd0, 16'd1000, BITS_8);
    send_fmt_file(FORMAT_PCM, 8'd3, 16'd1000, BITS_8);
    send_fmt_file(FORMAT_PCM, 8'hFF, 16'd1000, BITS_16);
    send_fmt_file(FORMAT_PCM, CHAN_MONO, 16'd1000, 8'd0);
    send_fmt_file(FORMAT_PCM, CHAN_MONO, 16'd1000, 8'd24);
    send_fmt_file(FORMAT_PCM, CHAN_STEREO, 16'd0, BITS_16);
    // a later fmt chunk replaces the earlier one
    make_file(ID_WAVE);
    put_fmt(FMT_LEN_MIN, FORMAT_PCM, CHAN_MONO, 16'd11025, BITS_8);
    put_fmt(18, FORMAT_PCM, CHAN_STEREO, 16'd48000, BITS_16);
    put_data(32'h0001_0000, 2);
    send_file(1'b1);
    // good fmt followed by an oversized one
    make_file(ID_WAVE);
    put_fmt(FMT_LEN_MIN, FORMAT_PCM, CHAN_MONO, 16'd11025, BITS_8);
    put_chunk_hdr(ID_FMT, 32'hFFFF_FFFF);
    send_file(1'b1);
  endtask

  task automatic test_timer_reload();
    logic [15:0] rates[3];
    rates = '{16'd1, 16'd255, 16'hFFFF};
    foreach (rates[k]) send_fmt_file(FORMAT_PCM, CHAN_STEREO, rates[k], BITS_16);
  endtask

  // mostly well-formed files with random content, some broken or cut short
  task automatic test_random_stream(input int min_bytes, input int min_results);
    int         bytes0;
    int         res0;
    int         files;
    int         kind;
    int         pick;
    int         len;
    logic [7:0] code;
    logic [7:0] chan;
    logic [7:0] bits;
    logic [15:0] rate;
    bit         mark_last;
    bytes0 = parsed_bytes;
    res0 = results_seen;
    files = 0;
    while (parsed_bytes - bytes0 < min_bytes || results_seen - res0 < min_results) begin
      kind = $urandom_range(99);
      make_file(kind < 4 ? 32'($urandom) : ID_WAVE);
      if ($urandom_range(99) < 30) put_skip_random();
      if ($urandom_range(99) < 85) begin
        code = ($urandom_range(99) < 95) ? FORMAT_PCM : 8'($urandom);
        chan = ($urandom_range(99) < 95) ? ($urandom_range(1) ? CHAN_STEREO : CHAN_MONO)
                                         : 8'($urandom);
        bits = ($urandom_range(99) < 95) ? ($urandom_range(1) ? BITS_16 : BITS_8)
                                         : 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 3) rate = 16'd0;
        else if (pick < 15) rate = 16'($urandom_range(255, 1));
        else rate = 16'($urandom_range(65535, 1));
        pick = $urandom_range(99);
        if (pick < 80) len = $urandom_range(20, 16);
        else if (pick < 88) len = $urandom_range(99, 21);
        else if (pick < 92) len = FMT_LEN_MAX;
        else if (pick < 96) len = $urandom_range(15);
        else len = $urandom_range(120, 101);
        put_fmt(len, code, chan, rate, bits);
      end
      if ($urandom_range(99) < 20) put_skip_random();
      // unknown chunk ahead of the data chunk
      if (kind >= 4 && kind < 9) put_chunk_hdr($urandom, $urandom_range(8));
      put_data($urandom, $urandom_range(3));
      mark_last = 1'($urandom_range(1));
      // cut short, with or without an end marker
      if (kind >= 9 && kind < 24) begin
        cut_file($urandom_range(file_bytes.size() - 1, 1));
        mark_last = (kind < 20);
      end
      send_file(mark_last);
      if ($urandom_range(99) < 10)
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
      files++;
      if (files % 12 == 0) drain_expected();
    end
  endtask

  initial begin
    rst       <= 1'b1;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    s_tlast   <= 1'b0;
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SPEED;
    cfg_data  <= '0;
    valid_up = 1'b0;
    src_calm = 1'b0;
    sink_calm = 1'b0;
    parsed_bytes = 0;
    results_seen = 0;
    errors = 0;
    speed_q = SPEED_RESET;
    clock_q = CLOCK_RESET;
    clear_parse_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_header_cases();
    test_fmt_cases();

    // divisor and clock extremes
    settle_idle();
    write_config(3'd7, 27'd100_000_000);
    test_timer_reload();
    settle_idle();
    write_config(3'd0, 27'd1);
    test_timer_reload();

    settle_idle();
    write_config(3'($urandom_range(7)), 27'($urandom_range(100_000_000, 1)));
    test_random_stream(40, 1);

    // long stretch with no gaps on either side
    settle_idle();
    write_config(3'd7, 27'd100_000_000);
    src_calm = 1'b1;
    sink_calm = 1'b1;
    test_random_stream(80, 1);
    src_calm = 1'b0;
    sink_calm = 1'b0;

    settle_idle();
    write_config(3'($urandom_range(7)), 27'($urandom_range(100_000_000, 1)));
    test_random_stream(40, 1);

    settle_idle();
    if (errors == 0) begin
      $display("wave_header_chunk_parser test passed");
    end else begin
      $display("wave_header_chunk_parser test failed");
    end
    $finish;
  end

endmodule
